// File: src/idict_pkg.sv
// ----------------------------------------------------------------------------
// idict_pkg: shared types and constants of the indexed value dictionary
// Table geometry, operation and status codes, controller states and the
// code width helper.
// ----------------------------------------------------------------------------
package idict_pkg;

    // table geometry
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int VAL_W    = 32;
    localparam int CW_W     = 3;
    localparam int MODE_W   = 2;
    localparam int STAT_W   = 2;

    // request operations
    typedef enum logic [MODE_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_ABSENT = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_RANGE  = 2'd3
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_READ,
        ST_DONE
    } state_t;

    // table write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  data;
    } ram_wr_t;

    // bit length of (n - 1), at least 1
    function automatic logic [CW_W-1:0] width_of(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] s;
        logic [CW_W-1:0]  w;
        begin
            s = (n != '0) ? n - CNT_W'(1) : '0;
            w = CW_W'(1);
            for (int i = 1; i < CNT_W; i++)
            begin
                if (s[i])
                begin
                    w = CW_W'(i + 1);
                end
            end
            return w;
        end
    endfunction

endpackage

// File: src/indexed_value_dictionary.sv
// ----------------------------------------------------------------------------
// indexed_value_dictionary: table of distinct values addressed by position
// Add, remove, find and read over a 64-entry value table held in RAM.
// ----------------------------------------------------------------------------
// Usage
//   Requests enter on the s_ channel: s_tuser carries the mode, s_tdata the
//   value and the code to read. Each request gives exactly one result on the
//   m_ channel: m_tuser carries the status, m_tdata the code, the read value,
//   the entry count and the code width.
//   Add, remove and find scan the table one entry per cycle through the RAM
//   read port; remove ends the scan at the match, then moves every later
//   entry down one place, one per cycle. Read of a code not below count
//   skips the RAM and returns the range status. Requests are handled one at
//   a time; the next one is taken once the current result sits in the output
//   register, even while that result still waits for m_tready.
//   A stalled receiver holds the result; the controller then waits with the
//   following result finished until the output register frees up.
//   Reset empties the table (count 0, code width 1) at once; the RAM
//   contents are not cleared, since only entries below count are read.
// ----------------------------------------------------------------------------
module indexed_value_dictionary
    import idict_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // request
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], code_in[37:32], zero pad
    input  logic [1:0]  s_tuser,   // mode[1:0]
    // result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // code_out[5:0], value_out[37:6],
                                   // entry_count[44:38], code_width[47:45]
    output logic [1:0]  m_tuser    // status[1:0]
);

    state_t             state_reg, state_next;
    op_t                mode_reg, mode_next;
    logic [VAL_W-1:0]   value_reg, value_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [ADDR_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic               pend_reg, pend_next;
    logic [ADDR_W-1:0]  res_code_reg, res_code_next;
    logic [VAL_W-1:0]   res_value_reg, res_value_next;
    status_t            res_status_reg, res_status_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CW_W-1:0]    width_reg, width_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [47:0]        m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    ram_wr_t            wr;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [VAL_W-1:0]   rd_data;
    logic               load_out;
    logic               hit;
    logic [ADDR_W-1:0]  req_code;

    idict_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_code = s_tdata[VAL_W +: ADDR_W];
    assign hit      = pend_reg && (rd_data == value_reg);

    // controller next state
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        value_next      = value_reg;
        idx_next        = idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        pend_next       = pend_reg;
        res_code_next   = res_code_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        count_next      = count_reg;
        width_next      = width_reg;
        wr              = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        s_tready        = 1'b0;
        load_out        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    mode_next       = op_t'(s_tuser);
                    value_next      = s_tdata[VAL_W-1:0];
                    idx_next        = '0;
                    pend_next       = 1'b0;
                    res_code_next   = '0;
                    res_value_next  = '0;
                    res_status_next = STAT_OK;
                    if (op_t'(s_tuser) == OP_READ)
                    begin
                        if (CNT_W'(req_code) < count_reg)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = req_code;
                            state_next = ST_READ;
                        end
                        else
                        begin
                            res_status_next = STAT_RANGE;
                            state_next      = ST_DONE;
                        end
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_READ:
            begin
                res_value_next = rd_data;
                state_next     = ST_DONE;
            end

            // linear scan, one entry per cycle
            ST_SEARCH:
            begin
                if (hit)
                begin
                    pend_next = 1'b0;
                    if (mode_reg == OP_REMOVE)
                    begin
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        res_code_next = cmp_idx_reg;
                        state_next    = ST_DONE;
                    end
                end
                else if (idx_reg < count_reg)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = idx_reg[ADDR_W-1:0];
                    cmp_idx_next = idx_reg[ADDR_W-1:0];
                    idx_next     = idx_reg + CNT_W'(1);
                    pend_next    = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_DONE;
                    if (mode_reg == OP_ADD)
                    begin
                        if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            wr.en         = 1'b1;
                            wr.addr       = count_reg[ADDR_W-1:0];
                            wr.data       = value_reg;
                            res_code_next = count_reg[ADDR_W-1:0];
                            count_next    = count_reg + CNT_W'(1);
                            width_next    = width_of(count_reg + CNT_W'(1));
                        end
                    end
                    else
                    begin
                        res_status_next = STAT_ABSENT;
                    end
                end
            end

            // move later entries down one place
            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    wr.en   = 1'b1;
                    wr.addr = cmp_idx_reg - ADDR_W'(1);
                    wr.data = rd_data;
                end
                if (idx_reg < count_reg)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = idx_reg[ADDR_W-1:0];
                    cmp_idx_next = idx_reg[ADDR_W-1:0];
                    idx_next     = idx_reg + CNT_W'(1);
                    pend_next    = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        width_next = width_of(count_reg - CNT_W'(1));
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pend_reg     <= 1'b0;
            count_reg    <= '0;
            width_reg    <= CW_W'(1);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            count_reg    <= count_next;
            width_reg    <= width_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        value_reg      <= value_next;
        idx_reg        <= idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_code_reg   <= res_code_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        if (load_out)
        begin
            m_tdata_reg <= {width_reg, count_reg, res_value_reg, res_code_reg};
            m_tuser_reg <= res_status_reg;
        end
    end

    // output register occupancy
    always_comb
    begin
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg && !m_tready;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // count never exceeds the table size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // code width tracks the count
    a_width_track: assert property (@(posedge clk) disable iff (!rst_n)
        width_reg == width_of(count_reg))
        else $error("code width out of step with count");

    // compaction writes stay inside the held entries
    a_shift_wr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && wr.en) |-> (CNT_W'(wr.addr) < count_reg))
        else $error("compaction write beyond count");

    // a result is only loaded into a free or draining output register
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!m_tvalid_reg || m_tready))
        else $error("result overwrote a pending output");

endmodule

// File: src/idict_ram.sv
// ----------------------------------------------------------------------------
// idict_ram: value table storage
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module idict_ram
    import idict_pkg::*;
(
    input  logic              clk,
    input  ram_wr_t           wr,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [VAL_W-1:0]  rd_data
);

    logic [VAL_W-1:0] mem [CAPACITY];
    logic [VAL_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
